>>> hdl/ecb_pkg.sv
// ecb_pkg: shared types and constants for the edge coverage bitmap
// holds item kinds, register indexes, controller states and the
// command/status structs between controller and datapath
`default_nettype none

package ecb_pkg;

  // field widths fixed by the item format
  localparam int unsigned KIND_W     = 2;
  localparam int unsigned ADDR_W     = 64;
  localparam int unsigned RIDX_W     = 16;
  localparam int unsigned OUT_IDX_W  = 16;
  localparam int unsigned COUNT_W    = 8;
  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 32;
  localparam int unsigned ITER_W     = 32;

  // register reset values
  localparam logic [ITER_W-1:0] MAX_ITER_RST = 32'd1000;

  // item kinds
  typedef enum logic [KIND_W-1:0] {
    KIND_EDGE = 2'd0,
    KIND_LOOP = 2'd1,
    KIND_READ = 2'd2
  } kind_e;

  // configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_TRACING_EN = 2'd0,
    CFG_PERSISTENT = 2'd1,
    CFG_MAX_ITER   = 2'd2
  } cfg_idx_e;

  // controller states
  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_EXEC,
    ST_MARK,
    ST_OUT
  } state_e;

  // controller to datapath
  typedef struct packed {
    logic accept;   // capture item, issue map read
    logic exec;     // update map and state, latch result
    logic clr;      // write zero at sweep address, advance sweep
    logic mark;     // finish first persistent loop call
    logic load;     // move result into output register
  } cmd_t;

  // datapath to controller
  typedef struct packed {
    logic need_clear;  // captured item is a first persistent loop call
    logic clear_last;  // sweep address is at the last entry
    logic out_free;    // output register can take a result
  } sts_t;

endpackage

`default_nettype wire

>>> hdl/ecb_ctrl.sv
// ecb_ctrl: controller state machine of the edge coverage bitmap
// depends on ecb_pkg; drives ecb_datapath through cmd_t, reads sts_t
`default_nettype none

module ecb_ctrl (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          in_valid_i,
  output logic               in_stall_o,
  input  wire ecb_pkg::sts_t sts_i,
  output ecb_pkg::cmd_t      cmd_o
);

  ecb_pkg::state_e state_q, state_d;
  logic            from_loop_q, from_loop_d;

  // state registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ecb_pkg::ST_CLEAR;
      from_loop_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      from_loop_q <= from_loop_d;
    end
  end

  // next state
  always_comb begin
    state_d     = state_q;
    from_loop_d = from_loop_q;
    unique case (state_q)
      ecb_pkg::ST_CLEAR: begin
        if (sts_i.clear_last) begin
          state_d     = from_loop_q ? ecb_pkg::ST_MARK : ecb_pkg::ST_IDLE;
          from_loop_d = 1'b0;
        end
      end
      ecb_pkg::ST_IDLE: begin
        if (in_valid_i) state_d = ecb_pkg::ST_EXEC;
      end
      ecb_pkg::ST_EXEC: begin
        if (sts_i.need_clear) begin
          state_d     = ecb_pkg::ST_CLEAR;
          from_loop_d = 1'b1;
        end else begin
          state_d = ecb_pkg::ST_OUT;
        end
      end
      ecb_pkg::ST_MARK: state_d = ecb_pkg::ST_OUT;
      ecb_pkg::ST_OUT: begin
        if (sts_i.out_free) state_d = ecb_pkg::ST_IDLE;
      end
      default: state_d = ecb_pkg::ST_CLEAR;
    endcase
  end

  // outputs
  always_comb begin
    cmd_o      = '0;
    in_stall_o = 1'b1;
    unique case (state_q)
      ecb_pkg::ST_CLEAR: cmd_o.clr = 1'b1;
      ecb_pkg::ST_IDLE: begin
        in_stall_o   = 1'b0;
        cmd_o.accept = in_valid_i;
      end
      ecb_pkg::ST_EXEC: cmd_o.exec = !sts_i.need_clear;
      ecb_pkg::ST_MARK: cmd_o.mark = 1'b1;
      ecb_pkg::ST_OUT:  cmd_o.load = sts_i.out_free;
      default: begin
        cmd_o      = '0;
        in_stall_o = 1'b1;
      end
    endcase
  end

endmodule

`default_nettype wire

>>> hdl/ecb_datapath.sv
// ecb_datapath: coverage map memory, location and iteration state,
// configuration registers and result registers of the edge coverage bitmap
// depends on ecb_pkg; controlled by ecb_ctrl
`default_nettype none

module ecb_datapath #(
  parameter int unsigned MAP_BITS = 16
) (
  input  wire logic                               clk_i,
  input  wire logic                               rst_ni,
  input  wire ecb_pkg::cmd_t                      cmd_i,
  output ecb_pkg::sts_t                           sts_o,
  input  wire logic [ecb_pkg::KIND_W-1:0]         kind_i,
  input  wire logic [ecb_pkg::ADDR_W-1:0]         block_address_i,
  input  wire logic [ecb_pkg::RIDX_W-1:0]         read_index_i,
  input  wire logic                               cfg_valid_i,
  input  wire logic [ecb_pkg::CFG_IDX_W-1:0]      cfg_index_i,
  input  wire logic [ecb_pkg::CFG_DATA_W-1:0]     cfg_data_i,
  output logic                                    out_valid_o,
  input  wire logic                               out_stall_i,
  output logic [ecb_pkg::OUT_IDX_W-1:0]           map_index_o,
  output logic [ecb_pkg::COUNT_W-1:0]             count_value_o,
  output logic                                    loop_continue_o,
  output logic                                    tracing_on_o
);

  localparam int unsigned ENTRIES = 2 ** MAP_BITS;

  // coverage map, one write and one registered read port
  logic [ecb_pkg::COUNT_W-1:0] map_mem [ENTRIES];
  logic                        mem_we;
  logic [MAP_BITS-1:0]         mem_wa;
  logic [ecb_pkg::COUNT_W-1:0] mem_wd;
  logic [MAP_BITS-1:0]         mem_ra;
  logic [ecb_pkg::COUNT_W-1:0] rd_q;

  // control state
  logic [MAP_BITS-1:0]        prev_q, prev_d;
  logic                       first_q, first_d;
  logic [ecb_pkg::ITER_W-1:0] iters_q, iters_d;
  logic                       active_q, active_d;
  logic                       en_q, en_d;
  logic                       pers_q, pers_d;
  logic [ecb_pkg::ITER_W-1:0] max_q, max_d;
  logic [MAP_BITS-1:0]        clr_cnt_q, clr_cnt_d;
  logic                       out_valid_q, out_valid_d;

  // captured item
  logic [ecb_pkg::KIND_W-1:0] kind_q;
  logic [MAP_BITS-1:0]        cur_q;
  logic [MAP_BITS-1:0]        idx_q;
  logic [ecb_pkg::RIDX_W-1:0] ridx_q;

  // result and output registers
  logic [ecb_pkg::OUT_IDX_W-1:0] res_idx_q, res_idx_d;
  logic [ecb_pkg::COUNT_W-1:0]   res_cnt_q, res_cnt_d;
  logic                          res_cont_q, res_cont_d;
  logic [ecb_pkg::OUT_IDX_W-1:0] out_idx_q;
  logic [ecb_pkg::COUNT_W-1:0]   out_cnt_q;
  logic                          out_cont_q;
  logic                          out_trace_q;

  // address forming
  logic [MAP_BITS-1:0]                    cur_in;
  logic [MAP_BITS+ecb_pkg::RIDX_W-1:0]    ridx_ext;
  logic [MAP_BITS+ecb_pkg::OUT_IDX_W-1:0] idx_ext;
  logic                                   trace_now;
  logic [ecb_pkg::COUNT_W-1:0]            cnt_inc;
  logic [ecb_pkg::ITER_W-1:0]             iters_dec;

  assign cur_in    = block_address_i[MAP_BITS:1];
  assign ridx_ext  = {{MAP_BITS{1'b0}}, read_index_i};
  assign idx_ext   = {{ecb_pkg::OUT_IDX_W{1'b0}}, idx_q};
  assign trace_now = en_q & active_q;
  assign cnt_inc   = rd_q + ecb_pkg::COUNT_W'(1);
  assign iters_dec = iters_q - ecb_pkg::ITER_W'(1);

  // read address chosen from the incoming item
  always_comb begin
    unique case (kind_i)
      ecb_pkg::KIND_EDGE: mem_ra = cur_in ^ prev_q;
      ecb_pkg::KIND_READ: mem_ra = ridx_ext[MAP_BITS-1:0];
      default:            mem_ra = '0;
    endcase
  end

  // map memory
  always_ff @(posedge clk_i) begin
    if (mem_we) map_mem[mem_wa] <= mem_wd;
    if (cmd_i.accept) rd_q <= map_mem[mem_ra];
  end

  // status to controller
  assign sts_o.need_clear = (kind_q == ecb_pkg::KIND_LOOP) & first_q & pers_q;
  assign sts_o.clear_last = &clr_cnt_q;
  assign sts_o.out_free   = !out_valid_q || !out_stall_i;

  // item execution, sweep and configuration
  always_comb begin
    prev_d      = prev_q;
    first_d     = first_q;
    iters_d     = iters_q;
    active_d    = active_q;
    en_d        = en_q;
    pers_d      = pers_q;
    max_d       = max_q;
    clr_cnt_d   = clr_cnt_q;
    res_idx_d   = res_idx_q;
    res_cnt_d   = res_cnt_q;
    res_cont_d  = res_cont_q;
    mem_we      = 1'b0;
    mem_wa      = '0;
    mem_wd      = '0;

    // clearing sweep
    if (cmd_i.clr) begin
      mem_we    = 1'b1;
      mem_wa    = clr_cnt_q;
      clr_cnt_d = clr_cnt_q + MAP_BITS'(1);
    end

    // end of first persistent loop call
    if (cmd_i.mark) begin
      mem_we     = 1'b1;
      mem_wd     = ecb_pkg::COUNT_W'(1);
      prev_d     = '0;
      iters_d    = max_q;
      first_d    = 1'b0;
      res_idx_d  = '0;
      res_cnt_d  = ecb_pkg::COUNT_W'(1);
      res_cont_d = 1'b1;
    end

    if (cmd_i.exec) begin
      res_idx_d  = '0;
      res_cnt_d  = '0;
      res_cont_d = 1'b0;
      unique case (kind_q)
        ecb_pkg::KIND_EDGE: begin
          if (trace_now) begin
            mem_we    = 1'b1;
            mem_wa    = idx_q;
            mem_wd    = cnt_inc;
            prev_d    = cur_q;
            res_idx_d = idx_ext[ecb_pkg::OUT_IDX_W-1:0];
            res_cnt_d = cnt_inc;
          end
        end
        ecb_pkg::KIND_LOOP: begin
          res_cnt_d = rd_q;
          priority if (first_q) begin
            // first call outside persistent mode
            iters_d    = max_q;
            first_d    = 1'b0;
            res_cont_d = 1'b1;
          end else if (pers_q) begin
            iters_d = iters_dec;
            if (iters_dec != '0) begin
              mem_we     = 1'b1;
              mem_wd     = ecb_pkg::COUNT_W'(1);
              prev_d     = '0;
              res_cnt_d  = ecb_pkg::COUNT_W'(1);
              res_cont_d = 1'b1;
            end else begin
              active_d = 1'b0;
            end
          end
        end
        ecb_pkg::KIND_READ: begin
          res_idx_d = ridx_q;
          res_cnt_d = rd_q;
        end
        default: begin
          res_idx_d = '0;
        end
      endcase
    end

    // register writes
    if (cfg_valid_i) begin
      unique case (cfg_index_i)
        ecb_pkg::CFG_TRACING_EN: begin
          en_d     = cfg_data_i[0];
          active_d = cfg_data_i[0];
        end
        ecb_pkg::CFG_PERSISTENT: pers_d = cfg_data_i[0];
        ecb_pkg::CFG_MAX_ITER:   max_d  = cfg_data_i;
        default:                 max_d  = max_q;
      endcase
    end
  end

  // output register handshake
  always_comb begin
    out_valid_d = out_valid_q;
    if (out_valid_q && !out_stall_i) out_valid_d = 1'b0;
    if (cmd_i.load) out_valid_d = 1'b1;
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prev_q      <= '0;
      first_q     <= 1'b1;
      iters_q     <= '0;
      active_q    <= 1'b1;
      en_q        <= 1'b1;
      pers_q      <= 1'b0;
      max_q       <= ecb_pkg::MAX_ITER_RST;
      clr_cnt_q   <= '0;
      out_valid_q <= 1'b0;
    end else begin
      prev_q      <= prev_d;
      first_q     <= first_d;
      iters_q     <= iters_d;
      active_q    <= active_d;
      en_q        <= en_d;
      pers_q      <= pers_d;
      max_q       <= max_d;
      clr_cnt_q   <= clr_cnt_d;
      out_valid_q <= out_valid_d;
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (cmd_i.accept) begin
      kind_q <= kind_i;
      cur_q  <= cur_in;
      idx_q  <= cur_in ^ prev_q;
      ridx_q <= read_index_i;
    end
    res_idx_q  <= res_idx_d;
    res_cnt_q  <= res_cnt_d;
    res_cont_q <= res_cont_d;
    if (cmd_i.load) begin
      out_idx_q   <= res_idx_q;
      out_cnt_q   <= res_cnt_q;
      out_cont_q  <= res_cont_q;
      out_trace_q <= trace_now;
    end
  end

  assign out_valid_o     = out_valid_q;
  assign map_index_o     = out_idx_q;
  assign count_value_o   = out_cnt_q;
  assign loop_continue_o = out_cont_q;
  assign tracing_on_o    = out_trace_q;

endmodule

`default_nettype wire

>>> hdl/edge_coverage_bitmap_top.sv
// edge coverage bitmap: an item passes through accept with registered map
// read, execute with map write and output load before the next item is
// taken; a stalled result holds the next item off
// reset: control and configuration registers return to defaults, payload
// and result registers are not reset, and the map is swept to zero with no
// item taken; a first loop call in persistent mode sweeps the map again
`default_nettype none

module edge_coverage_bitmap_top #(
  parameter int unsigned MAP_BITS = 16
) (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  input  wire logic                           in_valid_i,
  output logic                                in_stall_o,
  input  wire logic [ecb_pkg::KIND_W-1:0]     kind_i,
  input  wire logic [ecb_pkg::ADDR_W-1:0]     block_address_i,
  input  wire logic [ecb_pkg::RIDX_W-1:0]     read_index_i,
  output logic                                out_valid_o,
  input  wire logic                           out_stall_i,
  output logic [ecb_pkg::OUT_IDX_W-1:0]       map_index_o,
  output logic [ecb_pkg::COUNT_W-1:0]         count_value_o,
  output logic                                loop_continue_o,
  output logic                                tracing_on_o,
  input  wire logic                           cfg_valid_i,
  output logic                                cfg_ready_o,
  input  wire logic [ecb_pkg::CFG_IDX_W-1:0]  cfg_index_i,
  input  wire logic [ecb_pkg::CFG_DATA_W-1:0] cfg_data_i
);

  ecb_pkg::cmd_t cmd;
  ecb_pkg::sts_t sts;

  // register writes are always taken
  assign cfg_ready_o = 1'b1;

  // controller
  ecb_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  // datapath
  ecb_datapath #(
    .MAP_BITS (MAP_BITS)
  ) u_datapath (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cmd_i           (cmd),
    .sts_o           (sts),
    .kind_i          (kind_i),
    .block_address_i (block_address_i),
    .read_index_i    (read_index_i),
    .cfg_valid_i     (cfg_valid_i),
    .cfg_index_i     (cfg_index_i),
    .cfg_data_i      (cfg_data_i),
    .out_valid_o     (out_valid_o),
    .out_stall_i     (out_stall_i),
    .map_index_o     (map_index_o),
    .count_value_o   (count_value_o),
    .loop_continue_o (loop_continue_o),
    .tracing_on_o    (tracing_on_o)
  );

endmodule

`default_nettype wire
